// ----- hw/rtl/spg_pkg.sv -----
// Shared constants, types and helper functions of the Sobol point generator.
`default_nettype none

package spg_pkg;

    localparam int DIM_MAX   = 64;
    localparam int COLS      = 62;
    localparam int WORD_W    = 62;
    localparam int CNT_W     = 63;
    localparam int DIMS_W    = 7;
    localparam int DIM_W     = $clog2(DIM_MAX);
    localparam int COL_W     = 7;
    localparam int TAB_DEPTH = DIM_MAX * COLS;
    localparam int TAB_AW    = $clog2(TAB_DEPTH);
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam logic [1:0] FUNC_LOAD    = 2'd0;
    localparam logic [1:0] FUNC_RESTART = 2'd1;
    localparam logic [1:0] FUNC_GEN     = 2'd2;

    localparam logic [0:0] REG_DIMS_IN_USE = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_OVF,
        ST_SEED_RD,
        ST_SEED_WB,
        ST_GEN_RD,
        ST_GEN_WB
    } t_state;

    // Trailing one bits of a byte that is not all ones.
    function automatic logic [3:0] trailing_ones8(input logic [7:0] v);
        logic [3:0] n;
        logic       run;
        n   = 4'd0;
        run = 1'b1;
        for (int i = 0; i < 8; i++) begin
            if (run && v[i]) begin
                n = n + 4'd1;
            end else begin
                run = 1'b0;
            end
        end
        return n;
    endfunction

    // Row-major address of a direction word.
    function automatic logic [TAB_AW-1:0] tab_addr(input logic [DIM_W-1:0] d,
                                                   input logic [COL_W-1:0] c);
        return TAB_AW'(d) * TAB_AW'(COLS) + TAB_AW'(c);
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/sobol_point_generator.sv -----
// Top level of the Sobol point generator: sequencer, direction table and point memory.
//
//  channel   | direction | handshake               | payload
//  ----------+-----------+-------------------------+-------------------------------------------
//  in        | input     | i_in_valid / o_in_stall | func, dim_index, bit_index, direction_word
//  out       | output    | o_out_valid / i_out_stall | point_coord, coord_index, last, overflow
//  config    | input     | APB psel/penable/pready | dims_in_use at byte address 0
//
// A load or restart word is handled in the idle state. A generate word first counts the
// trailing ones of the sample counter (one byte per cycle), then reads and writes back the
// point memory for each dimension in use, after a seeding pass over every dimension in use
// on the first point after reset or restart. Reset clears the control state, sets the
// counter to one and dims_in_use to one, and marks every stored point as zero; the direction
// table holds nothing until loaded. Output stalls hold the walk in its write-back step.
`default_nettype none

module sobol_point_generator (
    input  wire                               i_clk,
    input  wire                               i_rst_n,

    input  wire                               i_in_valid,
    output logic                              o_in_stall,
    input  wire  [1:0]                        i_func,
    input  wire  [5:0]                        i_dim_index,
    input  wire  [5:0]                        i_bit_index,
    input  wire  [spg_pkg::WORD_W-1:0]        i_direction_word,

    output logic                              o_out_valid,
    input  wire                               i_out_stall,
    output logic [spg_pkg::WORD_W-1:0]        o_point_coord,
    output logic [5:0]                        o_coord_index,
    output logic                              o_last,
    output logic                              o_overflow,

    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire  [spg_pkg::APB_AW-1:0]        paddr,
    input  wire  [spg_pkg::APB_DW-1:0]        pwdata,
    output logic [spg_pkg::APB_DW-1:0]        prdata,
    output logic                              pready
);
    import spg_pkg::*;

    t_state              r_state, n_state;
    logic [DIM_W-1:0]    r_dim, n_dim;
    logic [COL_W-1:0]    r_col, n_col;
    logic [CNT_W-1:0]    r_scan, n_scan;
    logic [CNT_W-1:0]    r_counter, n_counter;
    logic [DIMS_W-1:0]   r_dims;
    logic [DIM_MAX-1:0]  r_lp_vld;

    logic                r_out_valid, n_out_valid;
    logic [WORD_W-1:0]   r_out_coord, n_out_coord;
    logic [DIM_W-1:0]    r_out_idx, n_out_idx;
    logic                r_out_last, n_out_last;
    logic                r_out_ovf, n_out_ovf;

    logic [WORD_W-1:0]   m_tab [TAB_DEPTH];
    logic [WORD_W-1:0]   m_lp [DIM_MAX];
    logic [WORD_W-1:0]   r_tab_q;
    logic [WORD_W-1:0]   r_lp_q;
    logic                r_lp_vld_q;

    logic                in_acc;
    logic                out_free;
    logic                cfg_wr;
    logic [DIM_W-1:0]    nd_last;
    logic [COL_W-1:0]    col_fin;
    logic [TAB_AW-1:0]   tab_raddr;
    logic                tab_we;
    logic [TAB_AW-1:0]   tab_waddr;
    logic                lp_we;
    logic [WORD_W-1:0]   lp_wdata;
    logic [WORD_W-1:0]   lp_cur;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign cfg_wr   = psel && penable && pwrite && pready;

    assign o_in_stall    = (r_state != ST_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_point_coord = r_out_coord;
    assign o_coord_index = r_out_idx;
    assign o_last        = r_out_last;
    assign o_overflow    = r_out_ovf;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_DIMS_IN_USE) ? APB_DW'(r_dims) : '0;

    // Index of the final dimension, with the register clamped to 1..DIM_MAX.
    always_comb begin
        priority if (r_dims == '0) begin
            nd_last = '0;
        end else if (r_dims > DIMS_W'(DIM_MAX)) begin
            nd_last = DIM_W'(DIM_MAX - 1);
        end else begin
            nd_last = DIM_W'(r_dims - DIMS_W'(1));
        end
    end

    assign col_fin   = r_col + COL_W'(trailing_ones8(r_scan[7:0]));
    assign tab_raddr = tab_addr(r_dim, (r_state == ST_SEED_RD) ? '0 : r_col);
    assign tab_waddr = tab_addr(i_dim_index, COL_W'(i_bit_index));
    assign tab_we    = in_acc && (i_func == FUNC_LOAD)
                       && ({1'b0, i_dim_index} < 7'(DIM_MAX))
                       && ({1'b0, i_bit_index} < 7'(COLS));
    assign lp_cur    = r_lp_vld_q ? r_lp_q : '0;

    always_comb begin
        n_state     = r_state;
        n_dim       = r_dim;
        n_col       = r_col;
        n_scan      = r_scan;
        n_counter   = r_counter;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_coord = r_out_coord;
        n_out_idx   = r_out_idx;
        n_out_last  = r_out_last;
        n_out_ovf   = r_out_ovf;
        lp_we       = 1'b0;
        lp_wdata    = r_tab_q;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (i_func)
                        FUNC_RESTART: n_counter = CNT_W'(1);
                        FUNC_GEN: begin
                            n_scan  = r_counter;
                            n_col   = '0;
                            n_dim   = '0;
                            n_state = ST_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                if (&r_scan[7:0]) begin
                    n_scan = r_scan >> 8;
                    n_col  = r_col + COL_W'(8);
                end else begin
                    n_col = col_fin;
                    priority if (col_fin >= COL_W'(COLS)) begin
                        n_state = ST_OVF;
                    end else if (r_counter == CNT_W'(1)) begin
                        n_state = ST_SEED_RD;
                    end else begin
                        n_state = ST_GEN_RD;
                    end
                end
            end
            ST_OVF: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_coord = '0;
                    n_out_idx   = '0;
                    n_out_last  = 1'b1;
                    n_out_ovf   = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            ST_SEED_RD: n_state = ST_SEED_WB;
            ST_SEED_WB: begin
                lp_we    = 1'b1;
                lp_wdata = r_tab_q;
                if (r_dim == nd_last) begin
                    n_dim   = '0;
                    n_state = ST_GEN_RD;
                end else begin
                    n_dim   = r_dim + DIM_W'(1);
                    n_state = ST_SEED_RD;
                end
            end
            ST_GEN_RD: n_state = ST_GEN_WB;
            ST_GEN_WB: begin
                // While the output is blocked the same addresses are read again each cycle.
                if (out_free) begin
                    lp_we       = 1'b1;
                    lp_wdata    = lp_cur ^ r_tab_q;
                    n_out_valid = 1'b1;
                    n_out_coord = lp_cur;
                    n_out_idx   = r_dim;
                    n_out_last  = (r_dim == nd_last);
                    n_out_ovf   = 1'b0;
                    if (r_dim == nd_last) begin
                        n_counter = r_counter + CNT_W'(1);
                        n_state   = ST_IDLE;
                    end else begin
                        n_dim   = r_dim + DIM_W'(1);
                        n_state = ST_GEN_RD;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_counter   <= CNT_W'(1);
            r_dims      <= DIMS_W'(1);
            r_lp_vld    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_counter   <= n_counter;
            r_out_valid <= n_out_valid;
            if (cfg_wr && (paddr[2] == REG_DIMS_IN_USE)) begin
                r_dims <= pwdata[DIMS_W-1:0];
            end
            if (lp_we) begin
                r_lp_vld[r_dim] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dim       <= n_dim;
        r_col       <= n_col;
        r_scan      <= n_scan;
        r_out_coord <= n_out_coord;
        r_out_idx   <= n_out_idx;
        r_out_last  <= n_out_last;
        r_out_ovf   <= n_out_ovf;
        r_lp_vld_q  <= r_lp_vld[r_dim];
    end

    always_ff @(posedge i_clk) begin
        if (tab_we) begin
            m_tab[tab_waddr] <= i_direction_word;
        end
        r_tab_q <= m_tab[tab_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (lp_we) begin
            m_lp[r_dim] <= lp_wdata;
        end
        r_lp_q <= m_lp[r_dim];
    end

endmodule

`default_nettype wire

// ----- tb/sobol_point_checker.sv -----
// Scoreboard of the Sobol point generator: predicts every coordinate word and checks the output.
`timescale 1ns / 1ps

module sobol_point_checker
    import spg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,

    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic [1:0]        i_func,
    input  logic [5:0]        i_dim_index,
    input  logic [5:0]        i_bit_index,
    input  logic [WORD_W-1:0] i_direction_word,

    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [WORD_W-1:0] i_point_coord,
    input  logic [5:0]        i_coord_index,
    input  logic              i_last,
    input  logic              i_overflow,

    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic              i_pready,
    input  logic [APB_AW-1:0] i_paddr,
    input  logic [APB_DW-1:0] i_pwdata,

    output int                o_error_count,
    output int                o_pending
);

    localparam logic [APB_AW-1:0] DIMS_ADDR   = APB_AW'(4 * REG_DIMS_IN_USE);
    localparam int                PRINT_LIMIT = 100;

    typedef struct packed {
        logic [WORD_W-1:0] coord;
        logic [5:0]        dim;
        logic              last;
        logic              ovf;
    } coord_word_t;

    coord_word_t       coord_fifo [$];
    logic [WORD_W-1:0] dir_words [DIM_MAX][COLS];
    logic [WORD_W-1:0] run_point [DIM_MAX];
    logic [CNT_W-1:0]  seq_count;
    logic [DIMS_W-1:0] dims_reg;
    int                err_cnt = 0;

    // Every mismatch is counted; printing stops after a while to keep the log short.
    task automatic report_mismatch(input string what);
        if (err_cnt < PRINT_LIMIT) begin
            $display("%0t ns mismatch: %s", $time, what);
        end
        err_cnt++;
    endtask

    function automatic int count_low_ones(input logic [CNT_W-1:0] v);
        int n;
        n = 0;
        while (n < CNT_W && v[n]) begin
            n++;
        end
        return n;
    endfunction

    task automatic predict_word(input logic [1:0] func, input logic [5:0] dim,
                                input logic [5:0] col, input logic [WORD_W-1:0] word);
        int          ndims;
        int          c;
        coord_word_t rec;
        case (func)
            FUNC_LOAD: begin
                if (int'(col) < COLS) begin
                    dir_words[dim][col] = word;
                end
            end
            FUNC_RESTART: begin
                seq_count = CNT_W'(1);
            end
            FUNC_GEN: begin
                if (dims_reg == '0) begin
                    ndims = 1;
                end else if (int'(dims_reg) > DIM_MAX) begin
                    ndims = DIM_MAX;
                end else begin
                    ndims = int'(dims_reg);
                end
                // The first point of a sequence starts from column 0, skipping point zero.
                if (seq_count == CNT_W'(1)) begin
                    for (int d = 0; d < ndims; d++) begin
                        run_point[d] = dir_words[d][0];
                    end
                end
                c = count_low_ones(seq_count);
                if (c >= COLS) begin
                    rec = '{coord: '0, dim: '0, last: 1'b1, ovf: 1'b1};
                    coord_fifo.push_back(rec);
                end else begin
                    for (int d = 0; d < ndims; d++) begin
                        rec = '{coord: run_point[d], dim: 6'(d), last: (d == ndims - 1),
                                ovf: 1'b0};
                        coord_fifo.push_back(rec);
                        run_point[d] = run_point[d] ^ dir_words[d][c];
                    end
                    seq_count = seq_count + CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic check_word();
        coord_word_t want;
        if (coord_fifo.size() == 0) begin
            report_mismatch($sformatf("coordinate word for dim %0d with none expected",
                                      i_coord_index));
        end else begin
            want = coord_fifo.pop_front();
            if (i_point_coord !== want.coord) begin
                report_mismatch($sformatf("dim %0d coordinate %h, expected %h",
                                          want.dim, i_point_coord, want.coord));
            end
            if (i_coord_index !== want.dim) begin
                report_mismatch($sformatf("coordinate index %0d, expected %0d",
                                          i_coord_index, want.dim));
            end
            if (i_last !== want.last) begin
                report_mismatch($sformatf("dim %0d last flag %b, expected %b",
                                          want.dim, i_last, want.last));
            end
            if (i_overflow !== want.ovf) begin
                report_mismatch($sformatf("dim %0d overflow flag %b, expected %b",
                                          want.dim, i_overflow, want.ovf));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            coord_fifo.delete();
            seq_count = CNT_W'(1);
            dims_reg  = DIMS_W'(1);
            for (int d = 0; d < DIM_MAX; d++) begin
                run_point[d] = '0;
            end
        end else begin
            if (i_out_valid && !i_out_stall) begin
                check_word();
            end
            if (i_in_valid && !i_in_stall) begin
                predict_word(i_func, i_dim_index, i_bit_index, i_direction_word);
            end
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == DIMS_ADDR) begin
                dims_reg = i_pwdata[DIMS_W-1:0];
            end
        end
        o_pending     <= coord_fifo.size();
        o_error_count <= err_cnt;
    end

endmodule

// ----- tb/sobol_point_generator_test.sv -----
// Top of the Sobol point generator testbench: clock, reset, stimulus, output stalls and verdict.
`timescale 1ns / 1ps

module sobol_point_generator_test;
    import spg_pkg::*;

    localparam int                CYCLE_LIMIT   = 1_000_000;
    localparam int                RANDOM_WORDS  = 420;
    localparam int                SETTLE_CYCLES = 40;
    localparam int                DRAIN_CYCLES  = 300;
    localparam int                HOLD_CYCLES   = 400;
    localparam logic [1:0]        FUNC_UNUSED   = 2'd3;
    localparam logic [APB_AW-1:0] DIMS_ADDR     = APB_AW'(4 * REG_DIMS_IN_USE);

    logic              i_clk            = 1'b0;
    logic              i_rst_n          = 1'b0;
    logic              i_in_valid       = 1'b0;
    logic              o_in_stall;
    logic [1:0]        i_func           = '0;
    logic [5:0]        i_dim_index      = '0;
    logic [5:0]        i_bit_index      = '0;
    logic [WORD_W-1:0] i_direction_word = '0;
    logic              o_out_valid;
    logic              i_out_stall      = 1'b0;
    logic [WORD_W-1:0] o_point_coord;
    logic [5:0]        o_coord_index;
    logic              o_last;
    logic              o_overflow;
    logic              psel             = 1'b0;
    logic              penable          = 1'b0;
    logic              pwrite           = 1'b0;
    logic [APB_AW-1:0] paddr            = '0;
    logic [APB_DW-1:0] pwdata           = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    int error_count;
    int pending;

    // Stimulus-side bookkeeping: which table entries hold a word, and the sample counter.
    logic             loaded [DIM_MAX][COLS];
    logic [CNT_W-1:0] gen_ctr     = CNT_W'(1);
    int               dims_eff    = 1;
    int               src_idle    = 22;
    int               dst_idle    = 76;
    int               sent_words  = 0;
    int               cycle_count = 0;
    logic             hold_req    = 1'b0;
    logic             hold_off    = 1'b0;

    sobol_point_generator u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_func           (i_func),
        .i_dim_index      (i_dim_index),
        .i_bit_index      (i_bit_index),
        .i_direction_word (i_direction_word),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_point_coord    (o_point_coord),
        .o_coord_index    (o_coord_index),
        .o_last           (o_last),
        .o_overflow       (o_overflow),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    sobol_point_checker u_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_func           (i_func),
        .i_dim_index      (i_dim_index),
        .i_bit_index      (i_bit_index),
        .i_direction_word (i_direction_word),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_point_coord    (o_point_coord),
        .i_coord_index    (o_coord_index),
        .i_last           (o_last),
        .i_overflow       (o_overflow),
        .i_psel           (psel),
        .i_penable        (penable),
        .i_pwrite         (pwrite),
        .i_pready         (pready),
        .i_paddr          (paddr),
        .i_pwdata         (pwdata),
        .o_error_count    (error_count),
        .o_pending        (pending)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= hold_off || (dst_idle > 0 && $urandom_range(99) < dst_idle);
    end

    // One long hold-off of the output, so the block backs up into its input.
    initial begin
        wait (hold_req);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    function automatic logic [WORD_W-1:0] rand_word();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return raw[WORD_W-1:0];
        endcase
    endfunction

    // Valid is only lowered when a gap is taken, so it never toggles within one step.
    task automatic send_word(input logic [1:0] func, input logic [5:0] dim,
                             input logic [5:0] col, input logic [WORD_W-1:0] word);
        if (src_idle > 0 && $urandom_range(99) < src_idle) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle);
        end
        i_in_valid       <= 1'b1;
        i_func           <= func;
        i_dim_index      <= dim;
        i_bit_index      <= col;
        i_direction_word <= word;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic load_word(input logic [5:0] dim, input logic [5:0] col,
                             input logic [WORD_W-1:0] word);
        send_word(FUNC_LOAD, dim, col, word);
        loaded[dim][col] = 1'b1;
        sent_words++;
    endtask

    task automatic fill_column(input int col);
        for (int d = 0; d < dims_eff; d++) begin
            if (!loaded[d][col]) begin
                load_word(6'(d), 6'(col), rand_word());
            end
        end
    endtask

    // A generate reads column 0 when it seeds and the lowest zero bit column of the counter,
    // so both are loaded for every dimension in use before the word goes out.
    task automatic gen_point();
        int c;
        c = $clog2(~gen_ctr & (gen_ctr + CNT_W'(1)));
        if (gen_ctr == CNT_W'(1)) begin
            fill_column(0);
        end
        fill_column(c);
        send_word(FUNC_GEN, 6'($urandom), 6'($urandom), rand_word());
        gen_ctr = gen_ctr + CNT_W'(1);
        sent_words++;
    endtask

    task automatic restart_seq();
        send_word(FUNC_RESTART, 6'($urandom), 6'($urandom), rand_word());
        gen_ctr = CNT_W'(1);
        sent_words++;
    endtask

    task automatic write_dims(input logic [DIMS_W-1:0] v);
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= DIMS_ADDR;
        pwdata  <= APB_DW'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (v == '0) begin
            dims_eff = 1;
        end else if (int'(v) > DIM_MAX) begin
            dims_eff = DIM_MAX;
        end else begin
            dims_eff = int'(v);
        end
    endtask

    task automatic random_word();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60) begin
            gen_point();
        end else if (pick < 63) begin
            restart_seq();
        end else if (pick < 83) begin
            load_word(6'($urandom_range(dims_eff - 1)), 6'($urandom_range(COLS - 1)),
                      rand_word());
        end else if (pick < 90) begin
            load_word(6'($urandom_range(DIM_MAX - 1)), 6'($urandom_range(COLS - 1)),
                      rand_word());
        end else if (pick < 95) begin
            send_word(FUNC_LOAD, 6'($urandom), 6'($urandom_range(63, COLS)), rand_word());
            sent_words++;
        end else begin
            send_word(FUNC_UNUSED, 6'($urandom), 6'($urandom), rand_word());
            sent_words++;
        end
    endtask

    initial begin
        int                phase;
        int                done_words;
        int                rand_start;
        int                phase_len;
        int                pick;
        logic [DIMS_W-1:0] dims_pick;

        foreach (loaded[d, c]) begin
            loaded[d][c] = 1'b0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words: field extremes, ignored words, restart and dimension count edges.
        write_dims(DIMS_W'(1));
        load_word(6'd0, 6'd0, '1);
        load_word(6'd0, 6'd1, {31{2'b01}});
        load_word(6'd0, 6'd2, '0);
        load_word(6'd0, 6'd3, WORD_W'(1));
        load_word(6'd1, 6'd0, '0);
        load_word(6'd63, 6'd61, '1);
        // Columns past the end must not land in the next row of the table.
        send_word(FUNC_LOAD, 6'd0, 6'd62, '1);
        send_word(FUNC_LOAD, 6'd63, 6'd63, '1);
        send_word(FUNC_UNUSED, '1, '1, '1);
        repeat (4) gen_point();
        restart_seq();
        gen_point();
        write_dims(DIMS_W'(0));
        gen_point();
        write_dims(DIMS_W'(2));
        gen_point();
        restart_seq();
        gen_point();

        rand_start = sent_words;
        phase      = 0;
        while (sent_words - rand_start < RANDOM_WORDS) begin
            done_words = sent_words - rand_start;
            if (done_words < RANDOM_WORDS / 3) begin
                src_idle = 22;
                dst_idle = 76;
            end else if (done_words < 2 * RANDOM_WORDS / 3) begin
                src_idle = 76;
                dst_idle = 22;
            end else begin
                src_idle = 0;
                dst_idle = 0;
            end
            case (phase)
                0: dims_pick = DIMS_W'(DIM_MAX);
                1: dims_pick = DIMS_W'(8);
                2: dims_pick = '1;
                default: begin
                    pick = $urandom_range(19);
                    if (pick == 0) begin
                        dims_pick = '0;
                    end else if (pick == 1) begin
                        dims_pick = DIMS_W'($urandom_range(127, DIM_MAX + 1));
                    end else if (pick < 5) begin
                        dims_pick = DIMS_W'($urandom_range(DIM_MAX, 7));
                    end else begin
                        dims_pick = DIMS_W'($urandom_range(6, 1));
                    end
                end
            endcase
            write_dims(dims_pick);
            if (phase == 1) begin
                hold_req = 1'b1;
            end
            phase_len = (dims_eff > 16) ? 6 : 20 + $urandom_range(20);
            for (int k = 0; k < phase_len && sent_words - rand_start < RANDOM_WORDS; k++) begin
                random_word();
            end
            phase++;
        end

        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/spg_pkg.sv
hw/rtl/sobol_point_generator.sv
tb/sobol_point_checker.sv
tb/sobol_point_generator_test.sv
